/* rtl/assert_macros.svh */
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// whenever ante holds, cons must hold in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

// cond must never hold
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

/* rtl/bbt_pkg.sv */
// types, constants and helpers of the bounding-box tracker
`default_nettype none

package bbt_pkg;

  // table geometry
  localparam int LABEL_COUNT = 4096;
  localparam int ADDR_BITS   = $clog2(LABEL_COUNT);
  localparam int COORD_BITS  = 12;
  localparam int LABEL_BITS  = 12;
  localparam int SIZE_BITS   = 13;
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [1:0] REG_X_SIZE = 2'd0;
  localparam logic [1:0] REG_Y_SIZE = 2'd1;
  localparam logic [1:0] REG_Z_SIZE = 2'd2;

  // function codes
  localparam logic [1:0] FUNC_VOXEL = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]  size_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  localparam size_t SIZE_MAX_EFF = size_t'(1 << COORD_BITS);

  // one table entry
  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  localparam int BOX_BITS = $bits(box_t);

  localparam box_t EMPTY_BOX = '{
    min_x: '1, min_y: '1, min_z: '1,
    max_x: '0, max_y: '0, max_z: '0
  };

  // classified transaction handed from front to back
  typedef struct packed {
    logic [1:0]            func;
    logic [LABEL_BITS-1:0] label;
    coord_t                x;
    coord_t                y;
    coord_t                z;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_push_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // zero acts as one, anything above the coordinate range is clamped
  function automatic size_t eff_size(size_t s);
    size_t r;
    if (s == '0) begin
      r = size_t'(1);
    end else if (s > SIZE_MAX_EFF) begin
      r = SIZE_MAX_EFF;
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic label_in_table(logic [LABEL_BITS-1:0] lbl);
    return (32'(lbl) < 32'(LABEL_COUNT));
  endfunction

endpackage

`default_nettype wire

/* rtl/label_bounding_box_tracker_core.sv */
// Bounding-box tracker for labelled volumes. Voxel labels arrive in raster
// order (x fastest, then y, then z) and the block keeps, per label, the
// smallest and largest column, row and slice seen; read transactions return
// one label's box with an empty flag, clear transactions reset one entry.
// After reset the 4096-entry table is swept clear, one entry a cycle, so
// input stall stays high until the sweep is done. The front end accepts a
// transaction and hands it through a two-entry queue to the back end, whose
// single table RAM sets the pace: a voxel or read transaction needs a
// registered read, then an update write or result load, a clear transaction
// only a write, and a result load waits while the output is held. Short
// bursts of up to three are absorbed by the queue. A read result sits in an
// output register and the front keeps accepting while it waits to be taken.
// The user must write size registers only while idle; the block does not check.
`default_nettype none

module label_bounding_box_tracker_core
  import bbt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            func,
  input  wire logic [LABEL_BITS-1:0] label,
  input  wire logic                  wr_en,
  input  wire logic [1:0]            wr_index,
  input  wire logic [SIZE_BITS-1:0]  wr_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [LABEL_BITS-1:0]      entry,
  output coord_t                     min_x,
  output coord_t                     min_y,
  output coord_t                     min_z,
  output coord_t                     max_x,
  output coord_t                     max_y,
  output coord_t                     max_z,
  output logic                       empty_res
);

  q_push_t q_in;
  q_head_t head;
  logic    q_full;
  logic    pop;
  logic    init_busy;

  // classification and position tracking
  bbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .label     (label),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .init_busy (init_busy),
    .q_full    (q_full),
    .q_in      (q_in)
  );

  // decoupling queue
  bbt_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_in (q_in),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  // table access and results
  bbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .entry     (entry),
    .min_x     (min_x),
    .min_y     (min_y),
    .min_z     (min_z),
    .max_x     (max_x),
    .max_y     (max_y),
    .max_z     (max_z),
    .empty_res (empty_res)
  );

endmodule

`default_nettype wire

/* rtl/bbt_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module bbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/bbt_front.sv */
// front end: size registers, voxel position counters and item classification
`default_nettype none

module bbt_front
  import bbt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            func,
  input  wire logic [LABEL_BITS-1:0] label,
  input  wire logic                  wr_en,
  input  wire logic [1:0]            wr_index,
  input  wire logic [SIZE_BITS-1:0]  wr_data,
  input  wire logic                  init_busy,
  input  wire logic                  q_full,
  output q_push_t                    q_in
);

  size_t  x_size;
  size_t  y_size;
  size_t  z_size;
  coord_t col_count;
  coord_t row_count;
  coord_t slice_count;
  coord_t col_count_next;
  coord_t row_count_next;
  coord_t slice_count_next;
  size_t  col_inc;
  size_t  row_inc;
  size_t  slice_inc;
  logic   accept;

  assign in_stall = init_busy || q_full;
  assign accept   = in_valid && !in_stall;

  // hand every meaningful transaction to the queue with its position
  always_comb begin
    q_in.push       = accept && (func != FUNC_NONE);
    q_in.item.func  = func;
    q_in.item.label = label;
    q_in.item.x     = col_count;
    q_in.item.y     = row_count;
    q_in.item.z     = slice_count;
  end

  // raster advance, x fastest then y then z
  always_comb begin
    col_inc          = {1'b0, col_count} + size_t'(1);
    row_inc          = {1'b0, row_count} + size_t'(1);
    slice_inc        = {1'b0, slice_count} + size_t'(1);
    col_count_next   = col_count;
    row_count_next   = row_count;
    slice_count_next = slice_count;
    if (col_inc < eff_size(x_size)) begin
      col_count_next = col_inc[COORD_BITS-1:0];
    end else begin
      col_count_next = '0;
      if (row_inc < eff_size(y_size)) begin
        row_count_next = row_inc[COORD_BITS-1:0];
      end else begin
        row_count_next = '0;
        if (slice_inc < eff_size(z_size)) begin
          slice_count_next = slice_inc[COORD_BITS-1:0];
        end else begin
          slice_count_next = '0;
        end
      end
    end
  end

  // counters move on voxel transactions only
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      slice_count <= '0;
    end else if (accept && (func == FUNC_VOXEL)) begin
      col_count   <= col_count_next;
      row_count   <= row_count_next;
      slice_count <= slice_count_next;
    end
  end

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_size <= size_t'(4096);
      y_size <= size_t'(4096);
      z_size <= size_t'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_X_SIZE: x_size <= wr_data;
        REG_Y_SIZE: y_size <= wr_data;
        REG_Z_SIZE: z_size <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/bbt_queue.sv */
// short fifo between front and back end
`default_nettype none

`include "assert_macros.svh"

module bbt_queue
  import bbt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_push_t q_in,
  output logic         full,
  output q_head_t      head,
  input  wire logic    pop
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PTR_BITS-1:0] ptr_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  item_t slots [QUEUE_DEPTH];
  ptr_t  wr_ptr;
  ptr_t  rd_ptr;
  cnt_t  count;
  logic  do_push;
  logic  do_pop;

  assign full       = (count == cnt_t'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];
  assign do_push    = q_in.push && !full;
  assign do_pop     = pop && head.valid;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_in.item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + cnt_t'(1);
      end else if (do_pop && !do_push) begin
        count <= count - cnt_t'(1);
      end
    end
  end

  `ASSERT_IMPLIES(a_no_push_when_full, clk, rst, q_in.push, !full)
  `ASSERT_NEVER(a_count_in_range, clk, rst, count > cnt_t'(QUEUE_DEPTH))

endmodule

`default_nettype wire

/* rtl/bbt_back.sv */
// back end: table clearing pass, read-modify-write of entries and result register
`default_nettype none

`include "assert_macros.svh"

module bbt_back
  import bbt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire q_head_t               head,
  output logic                       pop,
  output logic                       init_busy,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [LABEL_BITS-1:0]      entry,
  output coord_t                     min_x,
  output coord_t                     min_y,
  output coord_t                     min_z,
  output coord_t                     max_x,
  output coord_t                     max_y,
  output coord_t                     max_z,
  output logic                       empty_res
);

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  addr_t      init_addr;
  item_t      cur;
  logic       cur_in_table;
  logic       ram_we;
  addr_t      ram_waddr;
  box_t       ram_wdata;
  logic       ram_re;
  addr_t      ram_raddr;
  box_t       rd_box;
  box_t       upd_box;
  box_t       res_box;
  logic       out_free;
  logic       load_out;

  bbt_ram #(
    .WIDTH (BOX_BITS),
    .DEPTH (LABEL_COUNT)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (rd_box)
  );

  assign init_busy    = (state == ST_INIT);
  assign cur_in_table = label_in_table(cur.label);
  assign out_free     = !out_valid || !out_stall;
  assign res_box      = cur_in_table ? rd_box : EMPTY_BOX;

  // widen the stored box to take in the current voxel
  always_comb begin
    upd_box       = rd_box;
    upd_box.min_x = (cur.x < rd_box.min_x) ? cur.x : rd_box.min_x;
    upd_box.min_y = (cur.y < rd_box.min_y) ? cur.y : rd_box.min_y;
    upd_box.min_z = (cur.z < rd_box.min_z) ? cur.z : rd_box.min_z;
    upd_box.max_x = (cur.x > rd_box.max_x) ? cur.x : rd_box.max_x;
    upd_box.max_y = (cur.y > rd_box.max_y) ? cur.y : rd_box.max_y;
    upd_box.max_z = (cur.z > rd_box.max_z) ? cur.z : rd_box.max_z;
  end

  // sequencer
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = init_addr;
    ram_wdata  = EMPTY_BOX;
    ram_re     = 1'b0;
    ram_raddr  = addr_t'(head.item.label);
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_INIT: begin
        ram_we = 1'b1;
        if (init_addr == addr_t'(LABEL_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.func == FUNC_CLEAR) begin
            ram_we    = label_in_table(head.item.label);
            ram_waddr = addr_t'(head.item.label);
          end else begin
            ram_re     = 1'b1;
            state_next = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (cur.func == FUNC_VOXEL) begin
          ram_we     = cur_in_table;
          ram_waddr  = addr_t'(cur.label);
          ram_wdata  = upd_box;
          state_next = ST_IDLE;
        end else if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      init_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT) begin
        init_addr <= init_addr + addr_t'(1);
      end
    end
  end

  // transaction being worked on
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.item;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      entry     <= cur.label;
      min_x     <= res_box.min_x;
      min_y     <= res_box.min_y;
      min_z     <= res_box.min_z;
      max_x     <= res_box.max_x;
      max_y     <= res_box.max_y;
      max_z     <= res_box.max_z;
      empty_res <= (res_box.min_x > res_box.max_x);
    end
  end

  `ASSERT_IMPLIES(a_no_pop_in_init, clk, rst, state == ST_INIT, !pop)
  `ASSERT_IMPLIES(a_no_write_on_read, clk, rst, (state == ST_DATA) && (cur.func == FUNC_READ), !ram_we)
  `ASSERT_IMPLIES(a_result_after_read, clk, rst, $rose(out_valid), ($past(state) == ST_DATA) && ($past(cur.func) == FUNC_READ))
  `ASSERT_NEVER(a_read_and_write, clk, rst, ram_re && ram_we)

endmodule

`default_nettype wire
